@@ rtl/core/bsub_pkg.sv @@
`default_nettype none

package bsub_pkg;

    // field widths of the streams
    localparam int W_NODE = 16;
    localparam int W_PROB = 33;
    localparam int W_COL  = 6;
    localparam int W_DEG  = 7;

    // fixed point one, 2^32
    localparam logic [W_PROB-1:0] FX_ONE = 33'h1_0000_0000;

    // controller states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRIME,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT_OUT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic prime;
        logic walk;
        logic emit_rd;
        logic out_valid;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic row_end;
        logic walk_done;
        logic cnt_zero;
        logic out_done;
    } t_stat;

endpackage

`default_nettype wire

@@ rtl/core/bsub_in_if.sv @@
`default_nettype none

interface bsub_in_if;
    logic                           valid;
    logic                           ready;
    logic [bsub_pkg::W_NODE-1:0]    row_node;
    logic [bsub_pkg::W_PROB-1:0]    probability;
    logic [bsub_pkg::W_COL-1:0]     column;
    logic                           row_last;

    modport source (
        output valid, row_node, probability, column, row_last,
        input  ready
    );

    modport sink (
        input  valid, row_node, probability, column, row_last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/bsub_out_if.sv @@
`default_nettype none

interface bsub_out_if;
    logic                           valid;
    logic                           ready;
    logic [bsub_pkg::W_NODE-1:0]    out_node;
    logic [bsub_pkg::W_PROB-1:0]    out_probability;
    logic [bsub_pkg::W_COL-1:0]     out_column;
    logic [bsub_pkg::W_DEG-1:0]     out_degree;
    logic                           out_last;

    modport source (
        output valid, out_node, out_probability, out_column, out_degree, out_last,
        input  ready
    );

    modport sink (
        input  valid, out_node, out_probability, out_column, out_degree, out_last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/band_stochastic_upper_bound_row_top.sv @@
// Monotone upper bound of a sparse stochastic matrix, one row at a time.
// Input channel i_in: one nonzero entry per transfer (row_node, probability,
// column, row_last), columns ascending within a row, skipped columns are zero.
// Output channel o_out: one transfer per bound entry above the threshold, in
// ascending column order, each carrying the row's degree; out_last marks the
// final entry of the row. The first row passes through with threshold zero.
// Config: i_cfg_we writes i_cfg_wdata into the threshold register.
// An entry that does not end a row only loads the row store. A row end starts
// a setup step, a walk over each column of the merged band (high to low through
// the suffix memory), a readout start, then one transfer per emitted entry. The
// band walk over the suffix memory sets the row rate; input ready stays low from
// a row end until its last result is transferred. When the receiver stalls, the
// current result holds on o_out and the block waits. Reset (synchronous, active
// low) clears the bound and row state and the threshold; the next row with an
// accepted entry is treated as the first.
`default_nettype none

module band_stochastic_upper_bound_row_top #(
    parameter int MATRIX_SIZE = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bsub_pkg::W_PROB-1:0]    i_cfg_wdata,
    bsub_in_if.sink                       i_in,
    bsub_out_if.source                    o_out
);

    bsub_pkg::t_cmd  cmd;
    bsub_pkg::t_stat stat;

    // sequencer
    bsub_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // row store, band walk and readout
    bsub_dp #(
        .MATRIX_SIZE (MATRIX_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/core/bsub_ctrl.sv @@
`default_nettype none

module bsub_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire bsub_pkg::t_stat  i_stat,
    output bsub_pkg::t_cmd        o_cmd
);

    bsub_pkg::t_state r_state;
    bsub_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsub_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bsub_pkg::ST_LOAD: begin
                if (i_stat.row_end) n_state = bsub_pkg::ST_PRIME;
            end
            bsub_pkg::ST_PRIME: begin
                n_state = bsub_pkg::ST_WALK;
            end
            bsub_pkg::ST_WALK: begin
                if (i_stat.walk_done) n_state = bsub_pkg::ST_EMIT_RD;
            end
            bsub_pkg::ST_EMIT_RD: begin
                if (i_stat.cnt_zero) n_state = bsub_pkg::ST_LOAD;
                else                 n_state = bsub_pkg::ST_EMIT_OUT;
            end
            bsub_pkg::ST_EMIT_OUT: begin
                if (i_stat.out_done) n_state = bsub_pkg::ST_LOAD;
            end
            default: begin
                n_state = bsub_pkg::ST_LOAD;
            end
        endcase
    end

    // command decode
    always_comb begin
        o_cmd = '0;
        case (r_state)
            bsub_pkg::ST_LOAD:     o_cmd.in_ready  = 1'b1;
            bsub_pkg::ST_PRIME:    o_cmd.prime     = 1'b1;
            bsub_pkg::ST_WALK:     o_cmd.walk      = 1'b1;
            bsub_pkg::ST_EMIT_RD:  o_cmd.emit_rd   = 1'b1;
            bsub_pkg::ST_EMIT_OUT: o_cmd.out_valid = 1'b1;
            default:               o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/bsub_dp.sv @@
`default_nettype none

module bsub_dp #(
    parameter int MATRIX_SIZE = 64
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [bsub_pkg::W_PROB-1:0]    i_cfg_wdata,
    input  wire bsub_pkg::t_cmd           i_cmd,
    output bsub_pkg::t_stat               o_stat,
    bsub_in_if.sink                       i_in,
    bsub_out_if.source                    o_out
);

    localparam int AW = $clog2(MATRIX_SIZE);
    localparam int CW = $clog2(MATRIX_SIZE + 1);
    localparam logic [bsub_pkg::W_COL:0] SIZE_L = (bsub_pkg::W_COL + 1)'(MATRIX_SIZE);

    // memories: row entries in arrival order, bound suffix sums, passing results
    logic [bsub_pkg::W_COL-1:0]  r_ent_col_mem  [MATRIX_SIZE];
    logic [bsub_pkg::W_PROB-1:0] r_ent_prob_mem [MATRIX_SIZE];
    logic [bsub_pkg::W_PROB-1:0] r_bound_mem    [MATRIX_SIZE];
    logic [bsub_pkg::W_COL-1:0]  r_emit_col_mem [MATRIX_SIZE];
    logic [bsub_pkg::W_PROB-1:0] r_emit_val_mem [MATRIX_SIZE];

    logic [bsub_pkg::W_PROB-1:0] r_eps;
    logic [bsub_pkg::W_COL-1:0]  r_row_low, r_row_high, r_bound_low, r_bound_high;
    logic                        r_row_started, r_first_done;
    logic [CW-1:0]               r_n;
    logic [bsub_pkg::W_NODE-1:0] r_node;

    logic [bsub_pkg::W_COL-1:0]  r_j, r_jmin, r_jmax;
    logic [AW-1:0]               r_ptr;
    logic [bsub_pkg::W_COL-1:0]  r_ent_col;
    logic [bsub_pkg::W_PROB-1:0] r_ent_prob;
    logic [bsub_pkg::W_PROB-1:0] r_bs;
    logic [bsub_pkg::W_PROB-1:0] r_suf;
    logic [bsub_pkg::W_PROB-1:0] r_mprev;
    logic [CW-1:0]               r_cnt;
    logic [AW-1:0]               r_k;
    logic [bsub_pkg::W_COL-1:0]  r_emit_col;
    logic [bsub_pkg::W_PROB-1:0] r_emit_val;

    // input side
    logic                        in_acc;
    logic [bsub_pkg::W_PROB-1:0] in_prob;
    logic                        take;
    logic                        started_nx;
    logic [AW-1:0]               ent_wa;

    assign i_in.ready = i_cmd.in_ready;
    assign in_acc     = i_in.valid & i_cmd.in_ready;
    assign in_prob    = (i_in.probability > bsub_pkg::FX_ONE) ? bsub_pkg::FX_ONE
                                                               : i_in.probability;
    assign take       = ({1'b0, i_in.column} < SIZE_L) &&
                        (!r_row_started || (i_in.column > r_row_high));
    assign started_nx = r_row_started | take;
    assign ent_wa     = r_row_started ? r_n[AW-1:0] : '0;

    // walk range of the merged bound
    logic [bsub_pkg::W_COL-1:0] newmin, newmax;
    always_comb begin
        if (!r_first_done) begin
            newmin = r_row_low;
            newmax = r_row_high;
        end else begin
            newmin = (r_bound_low  > r_row_low)  ? r_bound_low  : r_row_low;
            newmax = (r_bound_high > r_row_high) ? r_bound_high : r_row_high;
        end
    end

    // walk step: suffix sum, merge, difference, threshold
    logic                        consume;
    logic [bsub_pkg::W_PROB-1:0] rv;
    logic [bsub_pkg::W_PROB:0]   sum;
    logic [bsub_pkg::W_PROB-1:0] suf;
    logic                        use_b, use_s;
    logic [bsub_pkg::W_PROB-1:0] merged;
    logic [bsub_pkg::W_PROB-1:0] val;
    logic [bsub_pkg::W_PROB-1:0] thr;
    logic                        pass;
    logic [bsub_pkg::W_COL-1:0]  j_m1;

    assign consume = (r_ent_col == r_j);
    assign rv      = consume ? r_ent_prob : '0;
    assign sum     = {1'b0, r_suf} + {1'b0, rv};
    assign suf     = (sum > {1'b0, bsub_pkg::FX_ONE}) ? bsub_pkg::FX_ONE
                                                       : sum[bsub_pkg::W_PROB-1:0];
    assign use_b   = r_first_done && (r_j <= r_bound_high);
    assign use_s   = (r_j <= r_row_high);
    assign j_m1    = r_j - 1'b1;

    always_comb begin
        if (use_b && use_s) merged = (r_bs > suf) ? r_bs : suf;
        else if (use_b)     merged = r_bs;
        else                merged = suf;
    end

    always_comb begin
        if (!r_first_done)         val = rv;
        else if (r_j == r_jmax)    val = merged;
        else if (merged >= r_mprev) val = merged - r_mprev;
        else                       val = '0;
    end

    assign thr  = r_first_done ? r_eps : '0;
    assign pass = (val > thr);

    // output side
    logic             out_xfer;
    logic [CW-1:0]    cnt_m1;
    logic [AW-1:0]    k_m1;
    logic [AW-1:0]    emit_ra;
    logic             emit_re;

    assign out_xfer = i_cmd.out_valid & o_out.ready;
    assign cnt_m1   = r_cnt - 1'b1;
    assign k_m1     = r_k - 1'b1;
    assign emit_re  = i_cmd.emit_rd | out_xfer;
    assign emit_ra  = i_cmd.emit_rd ? cnt_m1[AW-1:0] : k_m1;

    assign o_out.valid           = i_cmd.out_valid;
    assign o_out.out_node        = r_node;
    assign o_out.out_probability = r_emit_val;
    assign o_out.out_column      = r_emit_col;
    assign o_out.out_degree      = bsub_pkg::W_DEG'(r_cnt);
    assign o_out.out_last        = (r_k == '0);

    // status
    assign o_stat.row_end   = in_acc & i_in.row_last & started_nx;
    assign o_stat.walk_done = i_cmd.walk & (r_j == r_jmin);
    assign o_stat.cnt_zero  = (r_cnt == '0);
    assign o_stat.out_done  = out_xfer & (r_k == '0);

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= '0;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    // row collection and bound bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_low     <= '0;
            r_row_high    <= '0;
            r_row_started <= 1'b0;
            r_n           <= '0;
            r_bound_low   <= '0;
            r_bound_high  <= '0;
            r_first_done  <= 1'b0;
        end else begin
            if (in_acc) begin
                if (take) begin
                    if (!r_row_started) begin
                        r_row_low <= i_in.column;
                        r_n       <= CW'(1);
                    end else begin
                        r_n       <= r_n + 1'b1;
                    end
                    r_row_high <= i_in.column;
                end
                r_row_started <= started_nx & ~i_in.row_last;
            end
            if (o_stat.walk_done) begin
                r_bound_low  <= r_jmin;
                r_bound_high <= r_jmax;
                r_first_done <= 1'b1;
            end
        end
    end

    // node of the closing item
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.row_last) begin
            r_node <= i_in.row_node;
        end
    end

    // row entry store
    always_ff @(posedge i_clk) begin
        if (in_acc && take) begin
            r_ent_col_mem[ent_wa]  <= i_in.column;
            r_ent_prob_mem[ent_wa] <= in_prob;
        end
    end

    function automatic logic [AW-1:0] cnt_n_m1(input logic [CW-1:0] n);
        logic [CW-1:0] m;
        m = n - 1'b1;
        return m[AW-1:0];
    endfunction

    // row entry read, newest first
    logic [AW-1:0] ent_ra;
    assign ent_ra = i_cmd.prime ? cnt_n_m1(r_n) : (consume ? r_ptr - 1'b1 : r_ptr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prime || i_cmd.walk) begin
            r_ent_col  <= r_ent_col_mem[ent_ra];
            r_ent_prob <= r_ent_prob_mem[ent_ra];
            r_ptr      <= ent_ra;
        end
    end

    // bound suffix memory, read one column ahead of the walk
    logic [AW-1:0] bound_ra;
    assign bound_ra = i_cmd.prime ? newmax[AW-1:0] : j_m1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk) begin
            r_bound_mem[r_j[AW-1:0]] <= merged;
        end
        if (i_cmd.prime || i_cmd.walk) begin
            r_bs <= r_bound_mem[bound_ra];
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.prime) begin
            r_cnt <= '0;
        end else if (i_cmd.walk && pass) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prime) begin
            r_j    <= newmax;
            r_jmin <= newmin;
            r_jmax <= newmax;
            r_suf  <= '0;
        end else if (i_cmd.walk) begin
            r_j     <= j_m1;
            r_suf   <= suf;
            r_mprev <= merged;
        end
    end

    // passing results, stored highest column first
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk && pass) begin
            r_emit_col_mem[r_cnt[AW-1:0]] <= r_j;
            r_emit_val_mem[r_cnt[AW-1:0]] <= val;
        end
        if (emit_re) begin
            r_emit_col <= r_emit_col_mem[emit_ra];
            r_emit_val <= r_emit_val_mem[emit_ra];
            r_k        <= emit_ra;
        end
    end

endmodule

`default_nettype wire
